>>> hw/rtl/lcs_pkg.sv
// Shared types and constants for the line centroid steering block.
// Used by lcs_ctrl, lcs_dp, line_centroid_steering, steer_checker and tb_top; depends on nothing.
package lcs_pkg;

	// Frame geometry and accumulator sizes
	localparam int COL_W = 12;
	localparam int CNT_W = 25;
	localparam int SUM_W = 37;
	localparam int QUO_W = 12;

	localparam logic [12:0]      MAX_WIDTH_C = 13'd4096;
	localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};

	// Register reset values
	localparam logic [12:0] RST_FRAME_WIDTH = 13'd640;
	localparam logic [7:0]  RST_SAT_THR     = 8'd239;
	localparam logic [9:0]  RST_BASE_SPEED  = 10'd300;
	localparam logic [15:0] RST_STEER_GAIN  = 16'd256;
	localparam logic [14:0] RST_DRIVE_LIMIT = 15'd255;

	// Register indexes on the write port
	typedef enum logic [2:0] {
		CFG_FRAME_WIDTH = 3'd0,
		CFG_SAT_THR     = 3'd1,
		CFG_BASE_SPEED  = 3'd2,
		CFG_STEER_GAIN  = 3'd3,
		CFG_DRIVE_LIMIT = 3'd4
	} lcs_cfg_idx_t;

	// Configuration register file contents
	typedef struct packed {
		logic [12:0] frame_width;
		logic [7:0]  sat_thr;
		logic [9:0]  base_speed;
		logic [15:0] steer_gain;
		logic [14:0] drive_limit;
	} lcs_cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic pix_take;
		logic acc_load;
		logic div_step;
		logic err_load;
		logic mul_load;
		logic out_load;
	} lcs_cmd_t;

endpackage

>>> hw/rtl/lcs_ctrl.sv
// Sequencer for the line centroid steering block: pixel phase, end-of-frame
// divide, error, multiply and drive steps. Depends on lcs_pkg.
module lcs_ctrl import lcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tlast,
	output logic     s_tready,
	input  logic     m_tready,
	output logic     m_tvalid,
	output lcs_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_LOAD,
		ST_DIV,
		ST_ERR,
		ST_MUL,
		ST_DRIVE
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic       m_tvalid_q;

	// Decode commands from the state
	always_comb begin
		s_tready     = (state_q == ST_RUN);
		cmd.pix_take = s_tvalid && (state_q == ST_RUN);
		cmd.acc_load = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.err_load = (state_q == ST_ERR);
		cmd.mul_load = (state_q == ST_MUL);
		cmd.out_load = (state_q == ST_DRIVE) && (!m_tvalid_q || m_tready);
	end

	assign m_tvalid = m_tvalid_q;

	// Advance state, divide step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (cmd.pix_take && s_tlast) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					step_q  <= 4'(QUO_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 4'd0) begin
						state_q <= ST_ERR;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ST_ERR: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DRIVE;
				end
				ST_DRIVE: begin
					if (cmd.out_load) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_eof_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken right after end of frame");
	a_div_then_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == 4'd0) |=> cmd.err_load)
		else $error("divide did not hand over to error step");
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result valid without a load");
`endif

endmodule

>>> hw/rtl/lcs_dp.sv
// Datapath of the line centroid steering block: saturation mark, column
// accumulators, restoring divider, error, gain product and clamps. Depends on lcs_pkg.
module lcs_dp import lcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  lcs_cfg_t    cfg,
	input  lcs_cmd_t    cmd,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	input  logic        eof,
	output logic [15:0] left_drive,
	output logic [15:0] right_drive,
	output logic [11:0] centroid_x,
	output logic [12:0] steer_error,
	output logic        no_line
);

	logic [12:0]       eff_w;
	logic [COL_W-1:0]  col_q, col_cur, col_next;
	logic [12:0]       col_inc;
	logic [7:0]        mx, mn, diff;
	logic [16:0]       sat_lhs, sat_rhs;
	logic [15:0]       thr_mx;
	logic              mark;

	logic              valid_s1, mark_s1;
	logic [COL_W-1:0]  col_s1;

	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W:0]    sum_ext;

	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-2:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ovf_q, nol_q;
	logic              ge;

	logic [11:0]        cx_c;
	logic [11:0]        cx_q;
	logic signed [12:0] err_q;
	logic [11:0]        cx_out_q;
	logic signed [12:0] err_out_q;
	logic               nol_out_q;
	logic signed [29:0] prod_c, prod_q, prod_adj;
	logic signed [21:0] corr;
	logic signed [22:0] right_raw, lim, nlim, right_c;
	logic [15:0]        left_c;
	logic [15:0]        left_q, right_q;

	// Clip frame width to the supported span
	always_comb begin
		if (cfg.frame_width == 13'd0) begin
			eff_w = 13'd1;
		end else if (cfg.frame_width > MAX_WIDTH_C) begin
			eff_w = MAX_WIDTH_C;
		end else begin
			eff_w = cfg.frame_width;
		end
	end

	// Wrap the column counter at the frame width
	always_comb begin
		col_cur  = ({1'b0, col_q} >= eff_w) ? '0 : col_q;
		col_inc  = {1'b0, col_cur} + 13'd1;
		col_next = (col_inc >= eff_w) ? '0 : col_inc[COL_W-1:0];
	end

	// Mark a pixel when round(255*(max-min)/max) reaches the threshold
	always_comb begin
		mx = blue;
		mn = blue;
		if (green > mx) mx = green;
		if (red > mx) mx = red;
		if (green < mn) mn = green;
		if (red < mn) mn = red;
		diff    = mx - mn;
		sat_lhs = 17'(diff) * 17'd510 + 17'(mx);
		thr_mx  = cfg.sat_thr * mx;
		sat_rhs = {thr_mx, 1'b0};
		mark    = (cfg.sat_thr == 8'd0) || ((mx != 8'd0) && (sat_lhs >= sat_rhs));
	end

	// Register the mark and column; hold the column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.pix_take;
			if (cmd.pix_take) begin
				col_q <= eof ? '0 : col_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_take) begin
			mark_s1 <= mark;
			col_s1  <= col_cur;
		end
	end

	assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(col_s1);

	// Accumulate marked pixels with saturation; clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.acc_load) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (valid_s1 && mark_s1) begin
			if (count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
		end
	end

	assign ge = (rem_q >= {1'b0, dsh_q});

	// Restoring divide, one quotient bit a cycle, MSB first
	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			rem_q <= sum_q;
			dsh_q <= {count_q, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
			nol_q <= (count_q == '0);
			ovf_q <= (sum_q >= {count_q, {QUO_W{1'b0}}});
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - {1'b0, dsh_q};
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	// Centroid with saturation, then error against half width
	always_comb begin
		if (nol_q) begin
			cx_c = '0;
		end else if (ovf_q) begin
			cx_c = 12'hFFF;
		end else begin
			cx_c = quo_q;
		end
	end

	assign prod_c = err_q * $signed({1'b0, cfg.steer_gain});

	// Zero error when no pixel was marked
	always_ff @(posedge clk) begin
		if (cmd.err_load) begin
			cx_q  <= cx_c;
			err_q <= nol_q ? 13'sd0
				: ($signed({1'b0, cx_c}) - $signed({1'b0, eff_w[12:1]}));
		end
		if (cmd.mul_load) begin
			prod_q <= prod_c;
		end
	end

	// Truncate correction toward zero, steer and clamp both drives
	always_comb begin
		prod_adj  = prod_q + (prod_q[29] ? 30'sd255 : 30'sd0);
		corr      = prod_adj[29:8];
		right_raw = $signed({13'b0, cfg.base_speed}) - $signed({corr[21], corr});
		lim       = $signed({8'b0, cfg.drive_limit});
		nlim      = -lim;
		if (right_raw < nlim) begin
			right_c = nlim;
		end else if (right_raw > lim) begin
			right_c = lim;
		end else begin
			right_c = right_raw;
		end
		if ({5'b0, cfg.base_speed} > cfg.drive_limit) begin
			left_c = {1'b0, cfg.drive_limit};
		end else begin
			left_c = {6'b0, cfg.base_speed};
		end
	end

	// Load the whole result beat at once so a held beat stays intact
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			left_q    <= left_c;
			right_q   <= right_c[15:0];
			cx_out_q  <= cx_q;
			err_out_q <= err_q;
			nol_out_q <= nol_q;
		end
	end

	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign centroid_x  = cx_out_q;
	assign steer_error = err_out_q;
	assign no_line     = nol_out_q;

endmodule

>>> hw/rtl/line_centroid_steering.sv
// Top level of the line centroid steering block: register file, stream ports,
// controller and datapath. Depends on lcs_pkg, lcs_ctrl and lcs_dp.
//
//  channel  dir  fields
//  s_*      in   tdata: blue[7:0] green[15:8] red[23:16]; tlast: end_of_frame
//  m_*      out  tdata: left[15:0] right[31:16] cx[43:32] err[56:44]; tuser: no_line
//  cfg_*    in   cfg_index selects register, cfg_data holds its value
//
// One pixel is taken per cycle while the frame runs.
// After the end-of-frame pixel input stalls through one drain, one load,
// twelve restoring divide steps, then error, gain multiply and drive clamp.
// The final step waits while a previous result is still held on m_*.
// Reset clears counters, sums and control and loads the register defaults.
module line_centroid_steering import lcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue, green, red
	input  logic        s_tlast,   // end_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // left_drive, right_drive, centroid_x, steer_error, zeros
	output logic        m_tuser,   // no_line
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	lcs_cfg_t    cfg_q;
	lcs_cmd_t    cmd;
	logic [15:0] left_drive, right_drive;
	logic [11:0] centroid_x;
	logic [12:0] steer_error;
	logic        no_line;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= RST_FRAME_WIDTH;
			cfg_q.sat_thr     <= RST_SAT_THR;
			cfg_q.base_speed  <= RST_BASE_SPEED;
			cfg_q.steer_gain  <= RST_STEER_GAIN;
			cfg_q.drive_limit <= RST_DRIVE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data[12:0];
				CFG_SAT_THR:     cfg_q.sat_thr     <= cfg_data[7:0];
				CFG_BASE_SPEED:  cfg_q.base_speed  <= cfg_data[9:0];
				CFG_STEER_GAIN:  cfg_q.steer_gain  <= cfg_data;
				CFG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	lcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	lcs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.blue        (s_tdata[7:0]),
		.green       (s_tdata[15:8]),
		.red         (s_tdata[23:16]),
		.eof         (s_tlast),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.centroid_x  (centroid_x),
		.steer_error (steer_error),
		.no_line     (no_line)
	);

	// Pack the result beat
	assign m_tdata = {7'b0, steer_error, centroid_x, right_drive, left_drive};
	assign m_tuser = no_line;

endmodule

>>> tb/steer_checker.sv
// Scoreboard for line_centroid_steering: tracks register writes, predicts each
// frame result from the accepted pixel beats and compares the output beats.
// Depends on lcs_pkg for register indexes, reset values and accumulator limits.
module steer_checker
	import lcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // blue, green, red
	input  logic        s_tlast,   // end_of_frame
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // left_drive, right_drive, centroid_x, steer_error, zeros
	input  logic        m_tuser,   // no_line
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic [11:0] cx;
		logic [12:0] err;
		logic        no_line;
	} steer_result_t;

	steer_result_t steer_queue[$];

	// Register shadow copies
	logic [12:0] width_r;
	logic [7:0]  thr_r;
	logic [9:0]  base_r;
	logic [15:0] gain_r;
	logic [14:0] limit_r;

	// Frame accumulators
	int unsigned     column_count;
	longint unsigned marked_count;
	longint unsigned column_sum;

	initial errors = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int unsigned effective_width();
		int unsigned w;
		w = width_r;
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH_C)
			w = MAX_WIDTH_C;
		return w;
	endfunction

	// Rounded HSV saturation, zero for a black pixel
	function automatic int unsigned hsv_saturation(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		int unsigned mx, mn;
		mx = b;
		mn = b;
		if (g > mx) mx = g;
		if (r > mx) mx = r;
		if (g < mn) mn = g;
		if (r < mn) mn = r;
		if (mx == 0)
			return 0;
		return (2 * (mx - mn) * 255 + mx) / (2 * mx);
	endfunction

	function automatic longint clamp_drive(input longint v);
		longint lim;
		lim = longint'(limit_r);
		if (v < -lim)
			return -lim;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// Accumulate one pixel; on end of frame queue the steering result and restart
	function automatic void accumulate_pixel(input logic [23:0] px, input logic eof);
		int unsigned w, col;
		longint cx, err, prod, corr;
		steer_result_t res;
		w = effective_width();
		col = (column_count >= w) ? 0 : column_count;
		if (hsv_saturation(px[7:0], px[15:8], px[23:16]) >= thr_r) begin
			if (marked_count < COUNT_MAX)
				marked_count++;
			if (column_sum > SUM_MAX - col)
				column_sum = SUM_MAX;
			else
				column_sum += col;
		end
		column_count = (col + 1 >= w) ? 0 : col + 1;
		if (!eof)
			return;

		cx = 0;
		err = 0;
		res.no_line = 1'b1;
		if (marked_count != 0) begin
			cx = longint'(column_sum / marked_count);
			if (cx > 4095)
				cx = 4095;
			err = cx - longint'(w / 2);
			res.no_line = 1'b0;
		end
		// signed division truncates toward zero
		prod = err * longint'(gain_r);
		corr = prod / 256;
		res.left = 16'(clamp_drive(longint'(base_r)));
		res.right = 16'(clamp_drive(longint'(base_r) - corr));
		res.cx = 12'(cx);
		res.err = 13'(err);
		steer_queue.push_back(res);

		column_count = 0;
		marked_count = 0;
		column_sum = 0;
	endfunction

	task automatic compare_result(input logic [63:0] data, input logic flag);
		steer_result_t want;
		if (steer_queue.size() == 0) begin
			report_mismatch($sformatf("result beat with none expected, tdata %h", data));
			return;
		end
		want = steer_queue.pop_front();
		if (data[15:0] !== want.left)
			report_mismatch($sformatf("left_drive %0d, expected %0d",
				$signed(data[15:0]), $signed(want.left)));
		if (data[31:16] !== want.right)
			report_mismatch($sformatf("right_drive %0d, expected %0d",
				$signed(data[31:16]), $signed(want.right)));
		if (data[43:32] !== want.cx)
			report_mismatch($sformatf("centroid_x %0d, expected %0d", data[43:32], want.cx));
		if (data[56:44] !== want.err)
			report_mismatch($sformatf("steer_error %0d, expected %0d",
				$signed(data[56:44]), $signed(want.err)));
		if (data[63:57] !== '0)
			report_mismatch($sformatf("tdata padding %h, expected zero", data[63:57]));
		if (flag !== want.no_line)
			report_mismatch($sformatf("no_line %b, expected %b", flag, want.no_line));
	endtask

	// Follow writes, pixel beats and result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_r = RST_FRAME_WIDTH;
			thr_r = RST_SAT_THR;
			base_r = RST_BASE_SPEED;
			gain_r = RST_STEER_GAIN;
			limit_r = RST_DRIVE_LIMIT;
			column_count = 0;
			marked_count = 0;
			column_sum = 0;
			steer_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: width_r = cfg_data[12:0];
					CFG_SAT_THR:     thr_r = cfg_data[7:0];
					CFG_BASE_SPEED:  base_r = cfg_data[9:0];
					CFG_STEER_GAIN:  gain_r = cfg_data[15:0];
					CFG_DRIVE_LIMIT: limit_r = cfg_data[14:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				accumulate_pixel(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				compare_result(m_tdata, m_tuser);
		end
		pending = steer_queue.size();
	end

endmodule

>>> tb/tb_top.sv
// Top of the line_centroid_steering testbench: clock, reset, register writes,
// pixel stimulus and result back-pressure, plus the final verdict.
// Depends on lcs_pkg, line_centroid_steering and steer_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lcs_pkg::*;

	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 64;
	localparam int IDLE_PCT     = 15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tready = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [63:0] m_tdata;
	logic        m_tuser;

	int fail_count;
	int frames_pending;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit hold_pending = 1'b0;

	line_centroid_steering uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	steer_checker scoreboard (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (fail_count),
		.pending  (frames_pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	function automatic logic [23:0] bgr(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		return {r, g, b};
	endfunction

	// Mix gray, black, fully saturated and arbitrary pixels
	function automatic logic [23:0] random_pixel();
		logic [7:0] b, g, r;
		b = 8'($urandom);
		g = 8'($urandom);
		r = 8'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				g = b;
				r = b;
			end
			1: begin
				b = '0;
				g = '0;
				r = '0;
			end
			2, 3: begin
				case ($urandom_range(0, 2))
					0: b = '0;
					1: g = '0;
					default: r = '0;
				endcase
			end
			default: ;
		endcase
		return bgr(b, g, r);
	endfunction

	// Present one pixel beat and hold it until accepted
	task automatic send_pixel(input logic [23:0] px, input logic last);
		if (!calm && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_pixel(random_pixel(), i == len - 1);
	endtask

	// Drop valid, wait for every expected result, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (frames_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input lcs_cfg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input int w, input int thr, input int base, input int gain,
			input int lim);
		write_reg(CFG_FRAME_WIDTH, 16'(w));
		write_reg(CFG_SAT_THR, 16'(thr));
		write_reg(CFG_BASE_SPEED, 16'(base));
		write_reg(CFG_STEER_GAIN, 16'(gain));
		write_reg(CFG_DRIVE_LIMIT, 16'(lim));
		cfg_we <= 1'b0;
	endtask

	// Random settings, biased to narrow frames so the column counter wraps
	task automatic configure_random();
		int w, thr, base, gain, lim;
		case ($urandom_range(0, 7))
			0: w = 0;
			1: w = 8191;
			2: w = $urandom_range(1, 3);
			3: w = $urandom_range(1, 4096);
			default: w = $urandom_range(2, 40);
		endcase
		case ($urandom_range(0, 4))
			0: thr = 0;
			1: thr = 255;
			default: thr = $urandom_range(0, 255);
		endcase
		case ($urandom_range(0, 3))
			0: base = 0;
			1: base = 1023;
			default: base = $urandom_range(0, 1023);
		endcase
		case ($urandom_range(0, 4))
			0: gain = 0;
			1: gain = 65535;
			2: gain = $urandom_range(0, 1023);
			default: gain = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 4))
			0: lim = 0;
			1: lim = 32767;
			2: lim = $urandom_range(0, 600);
			default: lim = $urandom_range(0, 32767);
		endcase
		configure(w, thr, base, gain, lim);
	endtask

	initial begin
		int items;
		int len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty frames, black pixel, mixed frame, threshold edge
		send_pixel(bgr(128, 128, 128), 1'b1);
		send_pixel(bgr(0, 0, 0), 1'b1);
		send_pixel(bgr(255, 0, 0), 1'b0);
		send_pixel(bgr(0, 0, 0), 1'b0);
		send_pixel(bgr(0, 255, 0), 1'b0);
		send_pixel(bgr(0, 0, 255), 1'b1);
		send_pixel(bgr(255, 255, 255), 1'b0);
		send_pixel(bgr(255, 255, 0), 1'b1);
		send_pixel(bgr(255, 16, 16), 1'b0);
		send_pixel(bgr(255, 17, 17), 1'b1);

		// Width zero acts as one column; zero threshold marks every pixel
		settle();
		configure(0, 0, 1023, 65535, 32767);
		send_pixel(bgr(0, 0, 0), 1'b0);
		send_pixel(bgr(255, 255, 255), 1'b0);
		send_pixel(bgr(1, 2, 3), 1'b1);

		// Odd width, gain with a fraction: correction truncates toward zero both ways
		settle();
		configure(5, 255, 5, 301, 32767);
		send_pixel(bgr(255, 0, 0), 1'b0);
		repeat (3) send_pixel(bgr(90, 90, 90), 1'b0);
		send_pixel(bgr(90, 90, 90), 1'b1);
		repeat (4) send_pixel(bgr(40, 40, 40), 1'b0);
		send_pixel(bgr(0, 0, 200), 1'b1);

		// Random frames under changing settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			case (ph)
				0: configure(8191, $urandom_range(0, 255), 0, 0, 0);
				1: configure(4096, $urandom_range(0, 255), 1023, 65535,
					$urandom_range(0, 32767));
				default: configure_random();
			endcase
			calm = (ph == 5);
			if (ph == 3)
				hold_pending = 1'b1;
			items = 0;
			while (items < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150)
					: $urandom_range(1, 24);
				send_frame(len);
				items += len;
			end
		end

		settle();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> line_centroid_steering.f
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_ctrl.sv
hw/rtl/lcs_dp.sv
hw/rtl/line_centroid_steering.sv
tb/steer_checker.sv
tb/tb_top.sv
